@@ rtl/plist_pkg.sv @@
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types and constants of the positional ordered list: mode and status
// codes, and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package plist_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 8;
  localparam int CMP_W     = POS_W + 1;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic       load;
    logic       insert;
    logic       remove;
    logic       rotate;
    logic       emit;
    logic       emit_cell;
    logic       emit_last;
    logic [1:0] emit_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       slot_free;
    logic       ins_bad;
    logic       ins_full;
    logic       rem_bad;
    logic       empty;
    logic       rd_last;
  } stat_t;

endpackage

@@ rtl/plist_ctrl.sv @@
// ----------------------------------------------------------------------------
// plist_ctrl
// Controller state machine: takes one item, runs the insert, remove or
// read-out sequence on the cell datapath and issues its results; mode 3 ends without one.
// ----------------------------------------------------------------------------
module plist_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  plist_pkg::stat_t st,
  output plist_pkg::cmd_t  cmd
);
  import plist_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (st.mode)
          MODE_INSERT: begin
            if (st.slot_free) begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              if (st.ins_bad) begin
                cmd.emit_status = ST_BADPOS;
              end else if (st.ins_full) begin
                cmd.emit_status = ST_FULL;
              end else begin
                cmd.emit_status = ST_OK;
                cmd.insert      = 1'b1;
              end
              state_next = S_IDLE;
            end
          end
          MODE_REMOVE: begin
            if (st.slot_free) begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              if (st.rem_bad) begin
                cmd.emit_status = ST_BADPOS;
              end else begin
                cmd.emit_status = ST_OK;
                cmd.remove      = 1'b1;
              end
              state_next = S_IDLE;
            end
          end
          MODE_READ: begin
            if (st.empty) begin
              if (st.slot_free) begin
                cmd.emit        = 1'b1;
                cmd.emit_last   = 1'b1;
                cmd.emit_status = ST_EMPTY;
                state_next      = S_IDLE;
              end
            end else begin
              state_next = S_READ;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        if (st.slot_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_cell   = 1'b1;
          cmd.emit_last   = st.rd_last;
          cmd.emit_status = ST_OK;
          cmd.rotate      = 1'b1;
          if (st.rd_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/plist_cells.sv @@
// ----------------------------------------------------------------------------
// plist_cells
// Datapath: item capture registers, the chain of list cells with one-step
// shift and rotate, the entry count, the read index and the output register.
// ----------------------------------------------------------------------------
module plist_cells #(
  parameter int DEPTH = plist_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [1:0]                          mode,
  input  logic [plist_pkg::POS_W-1:0]         position,
  input  logic signed [plist_pkg::DATA_W-1:0] value,
  input  plist_pkg::cmd_t                     cmd,
  output plist_pkg::stat_t                    st,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [plist_pkg::DATA_W-1:0] data,
  output logic [1:0]                          status,
  output logic                                last
);
  import plist_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [1:0]        mode_q;
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] val_q;
  logic [CW-1:0]     count;
  logic [CW-1:0]     rd_idx;
  logic [DATA_W-1:0] cells      [DEPTH];
  logic [DATA_W-1:0] cells_next [DEPTH];

  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] pidx;

  assign pos_ext = {1'b0, pos_q};
  assign cnt_ext = CMP_W'(count);
  assign pidx    = pos_ext - CMP_W'(1);

  always_comb begin
    st           = '0;
    st.mode      = mode_q;
    st.slot_free = !out_valid || !out_stall;
    st.ins_bad   = (pos_q == '0) || (pos_ext > cnt_ext + CMP_W'(1));
    st.ins_full  = (count == CW'(DEPTH));
    st.rem_bad   = (pos_q == '0) || (pos_ext > cnt_ext);
    st.empty     = (count == '0);
    st.rd_last   = (rd_idx + CW'(1) == count);
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_W-1:0] up;
      logic [DATA_W-1:0] dn;
      if (g == DEPTH - 1) begin : g_tail
        assign up = cells[g];
      end else begin : g_mid
        assign up = cells[g+1];
      end
      if (g == 0) begin : g_head
        assign dn = cells[g];
      end else begin : g_rest
        assign dn = cells[g-1];
      end
      always_comb begin
        cells_next[g] = cells[g];
        if (cmd.insert) begin
          if (CMP_W'(g) == pidx) begin
            cells_next[g] = val_q;
          end else if (CMP_W'(g) > pidx) begin
            cells_next[g] = dn;
          end
        end else if (cmd.remove) begin
          if (CMP_W'(g) >= pidx) begin
            cells_next[g] = up;
          end
        end else if (cmd.rotate) begin
          if (CMP_W'(g) + CMP_W'(1) < cnt_ext) begin
            cells_next[g] = up;
          end else if (CMP_W'(g) + CMP_W'(1) == cnt_ext) begin
            cells_next[g] = cells[0];
          end
        end
      end
      always_ff @(posedge clk) begin
        cells[g] <= cells_next[g];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode;
      pos_q  <= position;
      val_q  <= value;
    end
    if (cmd.emit) begin
      data   <= cmd.emit_cell ? cells[0] : '0;
      status <= cmd.emit_status;
      last   <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.insert) begin
        count <= count + CW'(1);
      end else if (cmd.remove) begin
        count <= count - CW'(1);
      end
      if (cmd.load) begin
        rd_idx <= '0;
      end else if (cmd.rotate) begin
        rd_idx <= rd_idx + CW'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/positional_ordered_list_top.sv @@
// ----------------------------------------------------------------------------
// positional_ordered_list_top
// Ordered list of up to DEPTH signed 32-bit values with one-based positional
// insert and remove and a full in-order read-out.
// ----------------------------------------------------------------------------
// The list lives in a chain of DEPTH cells. An insert or remove is taken in
// the idle state; once the output register is free, the whole chain shifts at
// once and the single result is loaded into the output register. A read-out
// rotates the chain by one cell per cycle while the output is not stalled, the
// head cell going to the output register, so n entries stream n results and
// the list ends in its original order. An empty read-out gives one result
// with the empty status. The next item is taken while the last result still
// waits in the output register; a stalled output holds the chain. Mode 3 is
// dropped without a result. No clearing pass after reset.
// ----------------------------------------------------------------------------
module positional_ordered_list_top #(
  parameter int DEPTH = plist_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          mode,
  input  logic [plist_pkg::POS_W-1:0]         position,
  input  logic signed [plist_pkg::DATA_W-1:0] value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [plist_pkg::DATA_W-1:0] data,
  output logic [1:0]                          status,
  output logic                                last
);
  import plist_pkg::*;

  cmd_t  cmd;
  stat_t st;

  plist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  plist_cells #(
    .DEPTH (DEPTH)
  ) u_cells (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .position  (position),
    .value     (value),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data      (data),
    .status    (status),
    .last      (last)
  );

endmodule

@@ tb/sv/positional_ordered_list_top_tb.sv @@
// ----------------------------------------------------------------------------
// positional_ordered_list_top_tb
// Self-checking bench for the positional ordered list. A queue-based copy of
// the list predicts every result of each accepted item; a checker compares
// each returned result field by field. Directed items cover the empty and
// full list, the position bounds and the unused mode. Random traffic then
// grows and shrinks the list under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module positional_ordered_list_top_tb;
  import plist_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [1:0]        status;
    logic              last;
  } list_result_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               mode;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] data;
  logic [1:0]               status;
  logic                     last;

  logic signed [DATA_W-1:0] list_q[$];
  list_result_t             pending_q[$];
  list_result_t             head_result;
  int                       mismatches = 0;
  int                       quiet_cycles = 0;
  int                       send_idle_pct = 0;
  int                       recv_stall_pct = 0;
  bit                       growing = 1'b1;

  positional_ordered_list_top #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .position (position),
    .value    (value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .data     (data),
    .status   (status),
    .last     (last)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic void queue_result(input logic [DATA_W-1:0] d, input logic [1:0] st,
                                       input logic lst);
    list_result_t r;
    r.data = d;
    r.status = st;
    r.last = lst;
    pending_q.push_back(r);
  endfunction

  // list model update and expected results for one accepted item
  function automatic void predict_list(input logic [1:0] m, input logic [POS_W-1:0] pos,
                                       input logic signed [DATA_W-1:0] val);
    int n;
    int p;
    n = list_q.size();
    p = pos;
    case (m)
      MODE_INSERT: begin
        if (p == 0 || p > n + 1) begin
          queue_result('0, ST_BADPOS, 1'b1);
        end else if (n >= LIST_DEPTH) begin
          queue_result('0, ST_FULL, 1'b1);
        end else begin
          list_q.insert(p - 1, val);
          queue_result('0, ST_OK, 1'b1);
        end
      end
      MODE_REMOVE: begin
        if (p == 0 || p > n) begin
          queue_result('0, ST_BADPOS, 1'b1);
        end else begin
          list_q.delete(p - 1);
          queue_result('0, ST_OK, 1'b1);
        end
      end
      MODE_READ: begin
        if (n == 0) begin
          queue_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) queue_result(list_q[i], ST_OK, i == n - 1);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] m, input int pos,
                           input logic signed [DATA_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    mode <= m;
    position <= pos[POS_W-1:0];
    value <= val;
    do @(posedge clk); while (in_stall);
    predict_list(m, pos[POS_W-1:0], val);
  endtask

  task automatic test_empty_list();
    send_item(MODE_READ, $urandom_range(255), rand_value());
    send_item(MODE_REMOVE, 1, rand_value());
    send_item(MODE_INSERT, 0, rand_value());
    send_item(MODE_INSERT, 255, rand_value());
  endtask

  task automatic test_insert_order();
    send_item(MODE_INSERT, 1, 32'sh7fff_ffff);
    send_item(MODE_INSERT, 2, 32'sh8000_0000);
    send_item(MODE_INSERT, 1, '1);
    send_item(MODE_INSERT, 2, '0);
  endtask

  task automatic test_full_list();
    while (list_q.size() < LIST_DEPTH)
      send_item(MODE_INSERT, $urandom_range(list_q.size() + 1, 1), rand_value());
    send_item(MODE_INSERT, LIST_DEPTH + 1, rand_value());
    send_item(MODE_INSERT, LIST_DEPTH + 2, rand_value());
    send_item(MODE_READ, $urandom_range(255), rand_value());
  endtask

  task automatic test_remove_ends();
    send_item(MODE_REMOVE, list_q.size(), rand_value());
    send_item(MODE_REMOVE, 1, rand_value());
    send_item(MODE_REMOVE, list_q.size() + 1, rand_value());
    send_item(MODE_UNUSED, $urandom_range(255), rand_value());
    send_item(MODE_READ, $urandom_range(255), rand_value());
  endtask

  // mostly legal inserts and removes that sweep the fill level up and down
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_items);
    int sent;
    int n;
    int pick;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      n = list_q.size();
      pick = $urandom_range(99);
      if (growing && n == LIST_DEPTH && $urandom_range(3) == 0) growing = 1'b0;
      else if (!growing && n == 0) growing = 1'b1;
      else if ($urandom_range(19) == 0) growing = !growing;
      if (pick < 10) begin
        send_item(MODE_READ, $urandom_range(255), rand_value());
      end else if (pick < 13) begin
        send_item(MODE_UNUSED, $urandom_range(255), rand_value());
      end else if (pick < 20) begin
        send_item($urandom_range(1) ? MODE_INSERT : MODE_REMOVE, $urandom_range(255),
                  rand_value());
      end else if (growing) begin
        send_item(MODE_INSERT, $urandom_range(n + 1, 1), rand_value());
      end else begin
        send_item(MODE_REMOVE, (n == 0) ? 1 : $urandom_range(n, 1), rand_value());
      end
      sent++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result: data %0d status %0d last %0d", data, status, last);
        mismatches++;
      end else begin
        head_result = pending_q.pop_front();
        if (data !== head_result.data || status !== head_result.status ||
            last !== head_result.last) begin
          if (mismatches < MAX_REPORTS)
            $display("mismatch: expected data %0d status %0d last %0d, got %0d %0d %0d",
                     $signed(head_result.data), head_result.status, head_result.last,
                     data, status, last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_INSERT;
    position = '0;
    value = '0;
    out_stall = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_insert_order();
    test_full_list();
    test_remove_ends();
    test_random_traffic(0, 0, 75);
    test_random_traffic(64, 0, 75);
    test_random_traffic(0, 64, 76);
    test_random_traffic(22, 22, 76);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
